// ===== hdl/lbb_pkg.sv =====
// ----------------------------------------------------------------------------
// lbb_pkg: shared types and constants of the LED bitmap blink generator
// Command codes, field widths and the per-lane pattern record.
// ----------------------------------------------------------------------------
`default_nettype none

package lbb_pkg;

  localparam int CMD_W     = 3;
  localparam int CH_W      = 3;
  localparam int PAT_W     = 64;
  localparam int OFFSET_W  = 32;
  localparam int DELAY_W   = 8;
  localparam int MIRROR_W  = 8;
  localparam int OUT_W     = 5;
  localparam int NOW_W     = 32;
  localparam int STEP_W    = 6;
  // Only the low bits of a time difference reach the step index.
  localparam int PHASE_W   = 12;

  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FORCE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd4;

  typedef struct packed {
    logic [PAT_W-1:0]    pattern;
    logic [PHASE_W-1:0]  start_phase;
    logic [STEP_W-1:0]   delay;
    logic [MIRROR_W-1:0] mirror;
  } lane_cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [CH_W-1:0]     channel;
    logic [PAT_W-1:0]    pattern;
    logic [PHASE_W-1:0]  offset;
    logic [STEP_W-1:0]   delay;
    logic [MIRROR_W-1:0] mirror;
    logic                force_level;
  } req_t;

endpackage

`default_nettype wire

// ===== hdl/lbb_if.sv =====
// ----------------------------------------------------------------------------
// lbb_if: request and result channels of the LED bitmap blink generator
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbb_in_if;
  logic                            valid;
  logic                            ready;
  logic [lbb_pkg::CMD_W-1:0]       command;
  logic [lbb_pkg::CH_W-1:0]        channel;
  logic [lbb_pkg::PAT_W-1:0]       pattern;
  logic [lbb_pkg::OFFSET_W-1:0]    time_offset;
  logic [lbb_pkg::DELAY_W-1:0]     step_delay;
  logic [lbb_pkg::MIRROR_W-1:0]    mirror_start;
  logic                            force_level;

  modport source (output valid, command, channel, pattern, time_offset, step_delay,
                  mirror_start, force_level, input ready);
  modport sink (input valid, command, channel, pattern, time_offset, step_delay,
                mirror_start, force_level, output ready);
endinterface

interface lbb_out_if;
  logic                        valid;
  logic                        ready;
  logic [lbb_pkg::OUT_W-1:0]   pin_levels;
  logic [lbb_pkg::OUT_W-1:0]   pins_written;

  modport source (output valid, pin_levels, pins_written, input ready);
  modport sink (input valid, pin_levels, pins_written, output ready);
endinterface

`default_nettype wire

// ===== hdl/lbb_lane_store.sv =====
// ----------------------------------------------------------------------------
// lbb_lane_store: pattern memory of all lanes
// One record per lane, registered read, write data forwarded to a read in
// the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lbb_lane_store #(
  parameter int CHANNELS = 5
) (
  input  wire                    clk,
  input  wire                    rd_en,
  input  wire [CHANNELS-1:0]     wr_mask,
  input  wire lbb_pkg::lane_cfg_t wr_data,
  output lbb_pkg::lane_cfg_t     rd_data [CHANNELS]
);
  import lbb_pkg::*;

  lane_cfg_t mem [CHANNELS];
  lane_cfg_t rd_r [CHANNELS];

  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (wr_mask[c]) begin
        mem[c] <= wr_data;
      end
      // A read that meets a write of the same lane takes the new record.
      if (rd_en) begin
        rd_r[c] <= wr_mask[c] ? wr_data : mem[c];
      end
    end
  end

  assign rd_data = rd_r;

endmodule

`default_nettype wire

// ===== hdl/lbb_lane_eval.sv =====
// ----------------------------------------------------------------------------
// lbb_lane_eval: step index and bitmap level of one lane
// Works out the current step from the time and the lane record and picks
// the pattern bit.
// ----------------------------------------------------------------------------
`default_nettype none

module lbb_lane_eval (
  input  wire lbb_pkg::lane_cfg_t           cfg,
  input  wire [lbb_pkg::PHASE_W-1:0]        now_phase,
  output logic                              level
);
  import lbb_pkg::*;

  logic [PHASE_W-1:0] phase;
  logic [STEP_W-1:0]  step_raw;
  logic [STEP_W-1:0]  step;

  always_comb begin
    phase    = now_phase - cfg.start_phase;
    step_raw = phase[PHASE_W-1:PHASE_W-STEP_W] - cfg.delay;
    if (cfg.mirror != '0) begin
      step = cfg.mirror[STEP_W-1:0] - step_raw;
    end else begin
      step = step_raw;
    end
    // Step 0 sits in the most significant bit, so the bit index is ~step.
    level = cfg.pattern[~step];
  end

endmodule

`default_nettype wire

// ===== hdl/led_bitmap_blink_generator.sv =====
// ----------------------------------------------------------------------------
// led_bitmap_blink_generator: multi-channel LED bitmap blink generator
// Millisecond tick, per-lane 64-step bitmaps, forced levels and disable.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  in_req    sink       command, channel, pattern, time_offset, step_delay,
//                       mirror_start, force_level
//  out_rsp   source     pin_levels, pins_written
//
// One request per cycle while the result channel is not stalled. A request is accepted
// into the evaluation stage, where the lane records from the pattern memory arrive
// together with it; the result of that stage is registered onto out_rsp when out_rsp is free.
// Synchronous active-low reset clears the time, deactivates all lanes and clears the pins.
// A stalled result holds the evaluation stage; one more request waits there.
// ----------------------------------------------------------------------------
`default_nettype none

module led_bitmap_blink_generator #(
  parameter int CHANNELS = 5
) (
  input  wire       clk,
  input  wire       rst_n,
  lbb_in_if.sink    in_req,
  lbb_out_if.source out_rsp
);
  import lbb_pkg::*;

  logic                  s1_v_r;
  req_t                  s1_r;
  logic                  out_v_r;
  logic [OUT_W-1:0]      out_lv_r;
  logic [OUT_W-1:0]      out_wr_r;
  logic [NOW_W-1:0]      now_r;
  logic [CHANNELS-1:0]   active_r;
  logic [CHANNELS-1:0]   tracked_r;
  logic [CHANNELS-1:0]   pin_r;

  logic [NOW_W-1:0]      now_nxt;
  logic [CHANNELS-1:0]   active_nxt;
  logic [CHANNELS-1:0]   tracked_nxt;
  logic [CHANNELS-1:0]   pin_nxt;
  logic [CHANNELS-1:0]   written;
  logic [CHANNELS-1:0]   sel;
  logic [CHANNELS-1:0]   wr_mask;
  logic [CHANNELS-1:0]   lane_level;
  logic [31:0]           pin_ext;
  logic [31:0]           wr_ext;
  lane_cfg_t             wr_data;
  lane_cfg_t             rd_data [CHANNELS];
  logic                  in_fire;
  logic                  s1_fire;
  logic                  out_free;

  assign out_free     = !out_v_r || out_rsp.ready;
  assign s1_fire      = s1_v_r && out_free;
  assign in_req.ready = !s1_v_r || s1_fire;
  assign in_fire      = in_req.valid && in_req.ready;

  // The time advances before the lanes are evaluated on a tick.
  assign now_nxt = (s1_r.command == CMD_TICK) ? now_r + NOW_W'(1) : now_r;

  assign wr_data.pattern     = s1_r.pattern;
  assign wr_data.start_phase = now_r[PHASE_W-1:0] - s1_r.offset;
  assign wr_data.delay       = s1_r.delay;
  assign wr_data.mirror      = s1_r.mirror;

  lbb_lane_store #(.CHANNELS(CHANNELS)) u_store (
    .clk     (clk),
    .rd_en   (in_fire),
    .wr_mask (wr_mask),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    lbb_lane_eval u_eval (
      .cfg       (rd_data[g]),
      .now_phase (now_nxt[PHASE_W-1:0]),
      .level     (lane_level[g])
    );
  end

  always_comb begin
    active_nxt  = active_r;
    tracked_nxt = tracked_r;
    pin_nxt     = pin_r;
    written     = '0;
    wr_mask     = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      sel[c] = (32'(s1_r.channel) == c);
    end
    unique case (s1_r.command)
      CMD_TICK: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (!active_r[c]) begin
            // An idle lane that was left lit goes dark on the next tick.
            if (tracked_r[c]) begin
              pin_nxt[c]     = 1'b0;
              tracked_nxt[c] = 1'b0;
              written[c]     = 1'b1;
            end
          end else if (lane_level[c] != tracked_r[c]) begin
            pin_nxt[c]     = lane_level[c];
            tracked_nxt[c] = lane_level[c];
            written[c]     = 1'b1;
          end
        end
      end
      CMD_SET: begin
        active_nxt = active_r | sel;
        wr_mask    = s1_fire ? sel : '0;
      end
      CMD_CLEAR: begin
        active_nxt = active_r & ~sel;
      end
      CMD_FORCE: begin
        active_nxt  = active_r & ~sel;
        tracked_nxt = tracked_r & ~sel;
        pin_nxt     = (pin_r & ~sel) | (sel & {CHANNELS{s1_r.force_level}});
        written     = sel;
      end
      CMD_DISABLE: begin
        active_nxt  = '0;
        tracked_nxt = '0;
        pin_nxt     = '0;
        written     = '1;
      end
      default: begin
      end
    endcase
    pin_ext = 32'(pin_nxt);
    wr_ext  = 32'(written);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      now_r     <= '0;
      active_r  <= '0;
      tracked_r <= '0;
      pin_r     <= '0;
    end else begin
      if (in_req.ready) begin
        s1_v_r <= in_req.valid;
      end
      if (out_free) begin
        out_v_r <= s1_v_r;
      end
      if (s1_fire) begin
        now_r     <= now_nxt;
        active_r  <= active_nxt;
        tracked_r <= tracked_nxt;
        pin_r     <= pin_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.command     <= in_req.command;
      s1_r.channel     <= in_req.channel;
      s1_r.pattern     <= in_req.pattern;
      s1_r.offset      <= in_req.time_offset[PHASE_W-1:0];
      s1_r.delay       <= in_req.step_delay[STEP_W-1:0];
      s1_r.mirror      <= in_req.mirror_start;
      s1_r.force_level <= in_req.force_level;
    end
    if (s1_fire) begin
      out_lv_r <= pin_ext[OUT_W-1:0];
      out_wr_r <= wr_ext[OUT_W-1:0];
    end
  end

  assign out_rsp.valid        = out_v_r;
  assign out_rsp.pin_levels   = out_lv_r;
  assign out_rsp.pins_written = out_wr_r;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the LED bitmap blink generator
// Drives requests over the valid/ready request channel with random gaps,
// stalls the result channel at random, predicts the pin levels and the
// written mask of every request and compares each result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lbb_pkg::*;

  localparam int NCH           = 5;
  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 6;
  localparam int MAX_GAP       = 18;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int STEP_SHIFT    = 6;
  localparam int CMD_MAX       = (1 << CMD_W) - 1;
  localparam int CH_MAX        = (1 << CH_W) - 1;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [CH_W-1:0]     channel;
    logic [PAT_W-1:0]    pattern;
    logic [OFFSET_W-1:0] time_offset;
    logic [DELAY_W-1:0]  step_delay;
    logic [MIRROR_W-1:0] mirror_start;
    logic                force_level;
  } blink_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] pin_levels;
    logic [OUT_W-1:0] pins_written;
  } pin_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lbb_in_if  req_if ();
  lbb_out_if rsp_if ();

  led_bitmap_blink_generator #(
    .CHANNELS(NCH)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if),
    .out_rsp(rsp_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mirror of the block state, updated once per accepted request.
  logic [NOW_W-1:0]    now_ms = '0;
  logic [NCH-1:0]      active_q = '0;
  logic [PAT_W-1:0]    pattern_q [NCH];
  logic [NOW_W-1:0]    start_q [NCH];
  logic [DELAY_W-1:0]  delay_q [NCH];
  logic [MIRROR_W-1:0] mirror_q [NCH];
  logic [NCH-1:0]      tracked_q = '0;
  logic [NCH-1:0]      pins_q = '0;

  pin_result_t pins_expected [$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          cycles = 0;
  bit          in_quiet = 1'b0;
  bit          out_quiet = 1'b0;

  initial begin
    for (int c = 0; c < NCH; c++) begin
      pattern_q[c] = '0;
      start_q[c] = '0;
      delay_q[c] = '0;
      mirror_q[c] = '0;
    end
  end

  function automatic void drop_lane(input int c);
    active_q[c] = 1'b0;
    pattern_q[c] = '0;
    start_q[c] = '0;
    delay_q[c] = '0;
    mirror_q[c] = '0;
  endfunction

  function automatic pin_result_t predict_pins(input blink_req_t r);
    pin_result_t         res;
    logic [NOW_W-1:0]    elapsed;
    logic [NOW_W-1:0]    diff;
    logic [MIRROR_W-1:0] mdiff;
    logic [STEP_W-1:0]   step;
    logic                lit;
    logic [NCH-1:0]      wr;
    wr = '0;
    case (r.command)
      CMD_TICK: begin
        now_ms = now_ms + NOW_W'(1);
        for (int c = 0; c < NCH; c++) begin
          if (!active_q[c]) begin
            // An idle lane that was left on is switched off on the next tick.
            if (tracked_q[c]) begin
              pins_q[c] = 1'b0;
              tracked_q[c] = 1'b0;
              wr[c] = 1'b1;
            end
          end else begin
            elapsed = now_ms - start_q[c];
            diff = (elapsed >> STEP_SHIFT) - NOW_W'(delay_q[c]);
            step = diff[STEP_W-1:0];
            if (mirror_q[c] != '0) begin
              mdiff = mirror_q[c] - MIRROR_W'(step);
              step = mdiff[STEP_W-1:0];
            end
            lit = pattern_q[c][PAT_W-1-int'(step)];
            if (lit != tracked_q[c]) begin
              tracked_q[c] = lit;
              pins_q[c] = lit;
              wr[c] = 1'b1;
            end
          end
        end
      end
      CMD_SET: begin
        if (r.channel < NCH) begin
          active_q[r.channel] = 1'b1;
          pattern_q[r.channel] = r.pattern;
          delay_q[r.channel] = r.step_delay;
          mirror_q[r.channel] = r.mirror_start;
          start_q[r.channel] = now_ms - r.time_offset;
        end
      end
      CMD_CLEAR: begin
        if (r.channel < NCH) drop_lane(int'(r.channel));
      end
      CMD_FORCE: begin
        if (r.channel < NCH) begin
          drop_lane(int'(r.channel));
          tracked_q[r.channel] = 1'b0;
          pins_q[r.channel] = r.force_level;
          wr[r.channel] = 1'b1;
        end
      end
      CMD_DISABLE: begin
        for (int c = 0; c < NCH; c++) begin
          drop_lane(c);
          tracked_q[c] = 1'b0;
          pins_q[c] = 1'b0;
          wr[c] = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.pin_levels = pins_q;
    res.pins_written = wr;
    return res;
  endfunction

  function automatic blink_req_t rand_req(input logic [CMD_W-1:0] cmd,
                                          input logic [CH_W-1:0] ch);
    blink_req_t r;
    r.command = cmd;
    r.channel = ch;
    r.pattern = {$urandom, $urandom};
    r.time_offset = $urandom;
    r.step_delay = DELAY_W'($urandom_range(0, 255));
    r.mirror_start = MIRROR_W'($urandom_range(0, 255));
    r.force_level = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic send_req(input blink_req_t r);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.command <= r.command;
    req_if.channel <= r.channel;
    req_if.pattern <= r.pattern;
    req_if.time_offset <= r.time_offset;
    req_if.step_delay <= r.step_delay;
    req_if.mirror_start <= r.mirror_start;
    req_if.force_level <= r.force_level;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pins_expected.push_back(predict_pins(r));
    items_sent++;
  endtask

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] ch,
                          input logic lvl);
    blink_req_t r;
    r = rand_req(cmd, ch);
    r.force_level = lvl;
    send_req(r);
  endtask

  task automatic send_set(input logic [CH_W-1:0] ch, input logic [PAT_W-1:0] pat,
                          input logic [OFFSET_W-1:0] off,
                          input logic [DELAY_W-1:0] dly,
                          input logic [MIRROR_W-1:0] mir);
    blink_req_t r;
    r = rand_req(CMD_SET, ch);
    r.pattern = pat;
    r.time_offset = off;
    r.step_delay = dly;
    r.mirror_start = mir;
    send_req(r);
  endtask

  // A forced pin stays where it is on later ticks, since the tracked state
  // is cleared and the lane is idle.
  task automatic test_force_and_idle();
    send_cmd(CMD_TICK, 0, 1'b0);
    send_cmd(CMD_FORCE, 0, 1'b1);
    send_cmd(CMD_TICK, 0, 1'b0);
    send_cmd(CMD_FORCE, CH_W'(NCH - 1), 1'b0);
  endtask

  task automatic test_pattern_steps();
    send_set(1, '1, '0, '0, '0);
    send_cmd(CMD_TICK, 0, 1'b0);
    send_set(2, {1'b1, {(PAT_W-1){1'b0}}}, '1, '1, '0);
    // A mirror start of 64 is nonzero but folds to a plain negation.
    send_set(3, {{(PAT_W-1){1'b0}}, 1'b1}, 32'h0000_003f, '0, 8'h40);
    send_set(4, {(PAT_W/2){2'b01}}, 32'h8000_0000, 8'h80, '1);
    send_cmd(CMD_TICK, 0, 1'b0);
    send_cmd(CMD_TICK, 0, 1'b0);
  endtask

  task automatic test_clear_and_disable();
    send_cmd(CMD_CLEAR, 1, 1'b0);
    send_cmd(CMD_TICK, 0, 1'b0);
    send_cmd(CMD_FORCE, 2, 1'b1);
    send_cmd(CMD_TICK, 0, 1'b0);
    send_cmd(CMD_DISABLE, 0, 1'b1);
    send_cmd(CMD_TICK, 0, 1'b0);
    send_set(0, '0, '0, '0, '0);
    send_cmd(CMD_TICK, 0, 1'b0);
  endtask

  task automatic test_ignored_items();
    send_cmd(CMD_FORCE, CH_W'(CH_MAX), 1'b1);
    send_cmd(CMD_SET, CH_W'(NCH), 1'b1);
    send_cmd(CMD_CLEAR, CH_W'(CH_MAX - 1), 1'b0);
    for (int k = CMD_DISABLE + 1; k <= CMD_MAX; k++) begin
      send_cmd(CMD_W'(k), CH_W'($urandom_range(0, CH_MAX)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Mostly pattern loads followed by runs of ticks, with forces, clears,
  // disables and arbitrary requests mixed in.
  task automatic test_random_traffic();
    int         target;
    int         pick;
    int         ticks;
    blink_req_t r;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      in_quiet = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      ticks = $urandom_range(3, 40);
      if (pick < 65) begin
        repeat ($urandom_range(1, 3)) begin
          r = rand_req(CMD_SET, CH_W'($urandom_range(0, NCH - 1)));
          case ($urandom_range(0, 5))
            0: r.pattern = '0;
            1: r.pattern = '1;
            default: begin
            end
          endcase
          if ($urandom_range(0, 1) == 0) r.mirror_start = '0;
          send_req(r);
        end
      end else if (pick < 75) begin
        send_cmd(CMD_FORCE, CH_W'($urandom_range(0, NCH - 1)),
                 1'($urandom_range(0, 1)));
      end else if (pick < 85) begin
        send_cmd(CMD_CLEAR, CH_W'($urandom_range(0, NCH - 1)),
                 1'($urandom_range(0, 1)));
      end else if (pick < 89) begin
        send_cmd(CMD_DISABLE, CH_W'($urandom_range(0, CH_MAX)),
                 1'($urandom_range(0, 1)));
      end else begin
        ticks = $urandom_range(0, 4);
        repeat ($urandom_range(1, 6)) begin
          send_req(rand_req(CMD_W'($urandom_range(0, CMD_MAX)),
                            CH_W'($urandom_range(0, CH_MAX))));
        end
      end
      repeat (ticks) begin
        send_cmd(CMD_TICK, CH_W'($urandom_range(0, CH_MAX)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Result channel back-pressure.
  initial begin
    int gap;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = out_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_if.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    pin_result_t exp;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pins_expected.size() == 0) begin
        $display("%0t: unexpected result, expected none, got levels %b written %b",
                 $time, rsp_if.pin_levels, rsp_if.pins_written);
        mismatches++;
      end else begin
        exp = pins_expected.pop_front();
        if (rsp_if.pin_levels !== exp.pin_levels) begin
          $display("%0t: pin_levels mismatch, expected %b, got %b",
                   $time, exp.pin_levels, rsp_if.pin_levels);
          mismatches++;
        end
        if (rsp_if.pins_written !== exp.pins_written) begin
          $display("%0t: pins_written mismatch, expected %b, got %b",
                   $time, exp.pins_written, rsp_if.pins_written);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, pins_expected.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    req_if.valid <= 1'b0;
    req_if.command <= CMD_TICK;
    req_if.channel <= '0;
    req_if.pattern <= '0;
    req_if.time_offset <= '0;
    req_if.step_delay <= '0;
    req_if.mirror_start <= '0;
    req_if.force_level <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_force_and_idle();
    test_pattern_steps();
    test_clear_and_disable();
    test_ignored_items();
    test_random_traffic();

    req_if.valid <= 1'b0;
    out_quiet = 1'b0;
    while (pins_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
